@@ hw/rtl/pal_pkg.sv @@
package pal_pkg;

  // position and length width, wide enough for any supported list size
  localparam int unsigned PosW  = 11;
  localparam int unsigned WordW = 32;
  localparam int unsigned MaxHits = 32;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  typedef struct packed {
    cell_op_e               op;
    logic [PosW-1:0]        pos;
    logic [PosW-1:0]        used;
    logic signed [WordW-1:0] value;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/pal_cell.sv @@
module pal_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                           clk_i,
  input  pal_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [pal_pkg::WordW-1:0] left_i,
  input  logic signed [pal_pkg::WordW-1:0] right_i,
  output logic signed [pal_pkg::WordW-1:0] data_o,
  output logic signed [pal_pkg::WordW-1:0] rd_o,
  output logic                           hit_o
);
  import pal_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  logic signed [WordW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CELL_INS: begin
        if (MyIdx > ctrl_i.pos) begin
          data_d = left_i;
        end else if (MyIdx == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // one-hot read bus: only the addressed cell drives nonzero
  assign rd_o   = (MyIdx == ctrl_i.pos) ? data_q : '0;
  assign hit_o  = (data_q == ctrl_i.value) && (MyIdx < ctrl_i.used);

endmodule

@@ hw/rtl/positional_array_list_unit.sv @@
// Ordered list of up to CAPACITY signed 32-bit words held in a row of shift
// cells. Get, insert and delete each give one word; with the output side
// ready and no search scan running, a new item is taken every cycle. A
// search captures the match flags of all cells at once and shifts them
// toward cell 0 one position per cycle while the output side can take a
// word; it gives one word per match, or one word if there is none. At most
// 32 matches are reported; the last word of every item carries tlast.
// Insert and delete move every later cell in the same cycle. Slot contents
// are undefined after reset; only positions below the length are ever read.
module positional_array_list_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[1:0], position[7:2], value[39:8]
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], element[33:2], where[38:34], found[39], count[45:40]
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import pal_pkg::*;

  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  localparam int unsigned ScanW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PosW-1:0] CapExt = PosW'(CAPACITY);

  state_e state_q, state_d;
  logic [LenW-1:0]     used_q, used_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [ScanW-1:0]    scan_q, scan_d;
  logic [4:0]          hits_q, hits_d;

  logic                    out_vld_q, out_vld_d;
  logic [1:0]              out_stat_q, out_stat_d;
  logic signed [WordW-1:0] out_elem_q, out_elem_d;
  logic [4:0]              out_where_q, out_where_d;
  logic                    out_found_q, out_found_d;
  logic [5:0]              out_count_q, out_count_d;
  logic                    out_last_q, out_last_d;

  action_e                 act;
  logic [5:0]              pos_in;
  logic signed [WordW-1:0] val_in;
  logic [PosW-1:0]         pos_ext, used_ext, used_d_ext, scan_ext;
  logic                    out_free, s_acc, is_empty, is_full;
  logic                    more;
  cell_ctrl_t              ctrl;

  logic signed [WordW-1:0] data  [CAPACITY];
  logic signed [WordW-1:0] rd    [CAPACITY];
  logic [CAPACITY-1:0]     hit;
  logic signed [WordW-1:0] rd_word;

  assign act      = action_e'(s_axis_tdata_i[1:0]);
  assign pos_in   = s_axis_tdata_i[7:2];
  assign val_in   = s_axis_tdata_i[39:8];
  assign pos_ext  = PosW'(pos_in);
  assign used_ext = PosW'(used_q);
  assign used_d_ext = PosW'(used_d);
  assign scan_ext = PosW'(scan_q);
  assign is_empty = (used_ext == '0);
  assign is_full  = (used_ext >= CapExt);

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign more            = |match_q[CAPACITY-1:1];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WordW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_left
      assign left_w = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = data[i];
    end else begin : g_right
      assign right_w = data[i+1];
    end
    pal_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (data[i]),
      .rd_o   (rd[i]),
      .hit_o  (hit[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    match_d     = match_q;
    scan_d      = scan_q;
    hits_d      = hits_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_stat_d  = out_stat_q;
    out_elem_d  = out_elem_q;
    out_where_d = out_where_q;
    out_found_d = out_found_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    ctrl.op     = CELL_HOLD;
    ctrl.pos    = pos_ext;
    ctrl.used   = used_ext;
    ctrl.value  = val_in;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          out_elem_d  = '0;
          out_where_d = '0;
          out_found_d = 1'b0;
          out_last_d  = 1'b1;
          out_stat_d  = STAT_OK;
          unique case (act)
            ACT_GET, ACT_DELETE: begin
              if (is_empty) begin
                out_stat_d = STAT_EMPTY;
              end else if (pos_ext >= used_ext) begin
                out_stat_d = STAT_BAD_POS;
              end else begin
                out_elem_d = rd_word;
                if (act == ACT_DELETE) begin
                  ctrl.op = CELL_DEL;
                  used_d  = used_q - LenW'(1);
                end
              end
              out_vld_d = 1'b1;
            end
            ACT_INSERT: begin
              if (is_full) begin
                out_stat_d = STAT_FULL;
              end else if (pos_ext > used_ext) begin
                out_stat_d = STAT_BAD_POS;
              end else begin
                ctrl.op = CELL_INS;
                used_d  = used_q + LenW'(1);
              end
              out_vld_d = 1'b1;
            end
            default: begin
              match_d = hit;
              scan_d  = '0;
              hits_d  = '0;
              state_d = S_SCAN;
            end
          endcase
          out_count_d = used_d_ext[5:0];
        end
      end
      S_SCAN: begin
        if (out_free) begin
          out_stat_d  = STAT_OK;
          out_elem_d  = '0;
          out_count_d = used_ext[5:0];
          priority if (match_q == '0) begin
            // no match at all
            out_vld_d   = 1'b1;
            out_where_d = '0;
            out_found_d = 1'b0;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
          end else if (match_q[0]) begin
            out_vld_d   = 1'b1;
            out_where_d = scan_ext[4:0];
            out_found_d = 1'b1;
            out_last_d  = (hits_q == 5'(MaxHits - 1)) || !more;
            hits_d      = hits_q + 5'd1;
            if (out_last_d) begin
              state_d = S_IDLE;
            end
          end else begin
            out_vld_d = out_vld_q && !m_axis_tready_i;
          end
          match_d = match_q >> 1;
          scan_d  = scan_q + ScanW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      out_vld_q <= 1'b0;
      hits_q    <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
      hits_q    <= hits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q     <= match_d;
    scan_q      <= scan_d;
    out_stat_q  <= out_stat_d;
    out_elem_q  <= out_elem_d;
    out_where_q <= out_where_d;
    out_found_q <= out_found_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_count_q, out_found_q, out_where_q,
                            out_elem_q, out_stat_q};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_ext <= CapExt)
    else $error("list length above capacity");

  a_search_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && act == ACT_SEARCH) |=> (state_q == S_SCAN))
    else $error("search did not start a scan");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && act != ACT_SEARCH) |=> (out_vld_q && out_last_q))
    else $error("single result not presented with tlast");

  a_hits_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && hits_q != '0) |-> (match_q != '0))
    else $error("scan running after final match");

endmodule

@@ tb/tb_positional_array_list_unit.sv @@
`timescale 1ns / 100ps

module tb_positional_array_list_unit;
  import pal_pkg::*;

  localparam int unsigned Depth      = 32;
  localparam int unsigned RandItems  = 500;
  localparam int unsigned CalmItems  = 60;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned LongHold   = 150;

  typedef struct packed {
    action_e     act;
    logic [5:0]  pos;
    logic [31:0] val;
    logic        drain;  // hold this word back until all results are out
  } list_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] element;
    logic [4:0]         where;
    logic               found;
    logic [5:0]         count;
    logic               last;
  } list_word_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [39:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] out_data;
  logic        out_last;

  positional_array_list_unit #(
    .CAPACITY(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tlast_o (out_last)
  );

  list_req_t  pending[$];
  list_word_t expected_words[$];
  list_req_t  cur_req;

  // shadow list contents and length
  logic signed [31:0] slot_q[Depth];
  int unsigned        fill_q = 0;

  int unsigned gen_len = 0;
  int unsigned acc_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cnt = 0;
  int          errors = 0;
  logic        calm = 1'b0;
  bit          held_once = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic predict_list_op(input list_req_t r);
    list_word_t  w;
    int unsigned hits;
    w.status  = STAT_OK;
    w.element = '0;
    w.where   = '0;
    w.found   = 1'b0;
    w.last    = 1'b1;
    hits      = 0;
    case (r.act)
      ACT_GET: begin
        if (fill_q == 0) w.status = STAT_EMPTY;
        else if (r.pos >= fill_q) w.status = STAT_BAD_POS;
        else w.element = slot_q[r.pos];
      end
      ACT_INSERT: begin
        if (fill_q >= Depth) w.status = STAT_FULL;
        else if (r.pos > fill_q) w.status = STAT_BAD_POS;
        else begin
          for (int i = fill_q; i > r.pos; i--) slot_q[i] = slot_q[i-1];
          slot_q[r.pos] = r.val;
          fill_q++;
        end
      end
      ACT_DELETE: begin
        if (fill_q == 0) w.status = STAT_EMPTY;
        else if (r.pos >= fill_q) w.status = STAT_BAD_POS;
        else begin
          w.element = slot_q[r.pos];
          for (int i = r.pos; i + 1 < fill_q; i++) slot_q[i] = slot_q[i+1];
          fill_q--;
        end
      end
      default: begin
        w.count = 6'(fill_q);
        for (int i = 0; i < fill_q && hits < MaxHits; i++) begin
          if (slot_q[i] == $signed(r.val)) begin
            w.where = 5'(i);
            w.found = 1'b1;
            w.last  = 1'b0;
            expected_words.push_back(w);
            hits++;
          end
        end
        if (hits != 0) expected_words[expected_words.size()-1].last = 1'b1;
      end
    endcase
    w.count = 6'(fill_q);
    if (r.act != ACT_SEARCH || hits == 0) expected_words.push_back(w);
  endtask

  // queue one request and track the length it leaves behind
  task automatic add_req(input action_e a, input int unsigned p, input logic [31:0] v,
                         input bit drain);
    list_req_t r;
    r.act   = a;
    r.pos   = 6'(p);
    r.val   = v;
    r.drain = drain;
    pending.push_back(r);
    if (a == ACT_INSERT && gen_len < Depth && p <= gen_len) gen_len++;
    if (a == ACT_DELETE && gen_len > 0 && p < gen_len) gen_len--;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      acc_cnt  <= 0;
      calm     <= 1'b0;
    end else begin
      calm <= (pending.size() <= CalmItems);
      if (in_valid && in_ready) begin
        predict_list_op(cur_req);
        acc_cnt <= acc_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending[0].drain && (in_valid || expected_words.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          cur_req = pending.pop_front();
          in_data  <= {cur_req.val, cur_req.pos, cur_req.act};
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_n) begin
    list_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h last %b",
                   $time, out_data, out_last);
          errors++;
        end else begin
          w = expected_words.pop_front();
          compare_field("status", 32'(w.status), 32'(out_data[1:0]));
          compare_field("element", w.element, out_data[33:2]);
          compare_field("where", 32'(w.where), 32'(out_data[38:34]));
          compare_field("found", 32'(w.found), 32'(out_data[39]));
          compare_field("count", 32'(w.count), 32'(out_data[45:40]));
          compare_field("last", 32'(w.last), 32'(out_last));
        end
      end
      if (!held_once && acc_cnt >= 150) begin
        // long back-pressure so the block backs up into its input
        held_once = 1'b1;
        hold_left = LongHold;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cnt);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] pool[4];
    logic [31:0] v;
    int unsigned n_rand;
    int unsigned mode;
    int unsigned span;
    int unsigned pick;
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned p;
    action_e     a;

    // directed: empty list, bad positions, extreme values
    add_req(ACT_GET, 0, 32'd0, 1'b0);
    add_req(ACT_DELETE, 0, 32'd0, 1'b0);
    add_req(ACT_SEARCH, 0, 32'd0, 1'b0);
    add_req(ACT_INSERT, 1, 32'd5, 1'b0);
    add_req(ACT_INSERT, 0, 32'h7fff_ffff, 1'b0);
    add_req(ACT_INSERT, 0, 32'h8000_0000, 1'b0);
    add_req(ACT_INSERT, 2, 32'd0, 1'b0);
    add_req(ACT_INSERT, 1, 32'hffff_ffff, 1'b0);
    for (int i = 0; i < 5; i++) add_req(ACT_GET, i, 32'd0, 1'b0);
    add_req(ACT_GET, 63, 32'd0, 1'b0);
    add_req(ACT_SEARCH, 0, 32'hffff_ffff, 1'b0);
    add_req(ACT_SEARCH, 0, 32'd5, 1'b0);
    add_req(ACT_DELETE, 63, 32'd0, 1'b0);
    add_req(ACT_DELETE, 4, 32'd0, 1'b0);
    add_req(ACT_DELETE, 0, 32'd0, 1'b0);
    add_req(ACT_DELETE, 2, 32'd0, 1'b0);
    add_req(ACT_INSERT, 63, 32'h8000_0000, 1'b0);
    add_req(ACT_SEARCH, 0, 32'h7fff_ffff, 1'b1);

    // small value pool so searches hit often
    pool[0] = 32'd0;
    pool[1] = 32'hffff_ffff;
    pool[2] = $urandom;
    pool[3] = $urandom;

    n_rand = 0;
    mode   = 6;  // start by filling with one value
    while (n_rand < RandItems) begin
      if (mode == 6) begin
        // fill the rest of the list with one value, then insert into full and search for that value
        v = pool[$urandom_range(0, 3)];
        while (gen_len < Depth) begin
          add_req(ACT_INSERT, $urandom_range(0, gen_len), v, 1'b0);
          n_rand++;
        end
        add_req(ACT_INSERT, $urandom_range(0, 63), $urandom, 1'b0);
        add_req(ACT_SEARCH, 0, v, 1'b0);
        add_req(ACT_GET, Depth - 1, 32'd0, 1'b0);
        add_req(ACT_GET, Depth, 32'd0, 1'b0);
        n_rand += 4;
      end else begin
        if (mode < 2) begin
          ins_pct = 60;
          del_pct = 10;
        end else if (mode < 4) begin
          ins_pct = 10;
          del_pct = 60;
        end else begin
          ins_pct = 30;
          del_pct = 30;
        end
        span = $urandom_range(20, 60);
        repeat (span) begin
          pick = $urandom_range(0, 99);
          if (pick < ins_pct) a = ACT_INSERT;
          else if (pick < ins_pct + del_pct) a = ACT_DELETE;
          else if (pick < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) a = ACT_GET;
          else a = ACT_SEARCH;
          if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 63);
          else if (a == ACT_INSERT) p = $urandom_range(0, gen_len);
          else if (gen_len != 0) p = $urandom_range(0, gen_len - 1);
          else p = 0;
          v = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 3)] : $urandom;
          add_req(a, p, v, (n_rand % 100) == 99);
          n_rand++;
        end
      end
      mode = $urandom_range(0, 6);
    end

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pal_pkg.sv
hw/rtl/pal_cell.sv
hw/rtl/positional_array_list_unit.sv
tb/tb_positional_array_list_unit.sv
